// ----- src/saxis_pkg.sv -----
// Shared types, constants and the control store for the sorted axis index search.
// Used by saxis_seq and sorted_axis_index_search_core; depends on nothing.
package saxis_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int CNT_W  = 13;
    localparam int WIDX_W = 12;
    localparam int SMP_W  = 32;
    localparam int FIDX_W = 12;
    localparam int SPC_W  = 32;

    localparam logic FN_WRITE = 1'b0;
    localparam logic FN_QUERY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [WIDX_W-1:0] write_index;
        logic [SMP_W-1:0]  sample_value;
        logic [SMP_W-1:0]  query_wavelength;
    } t_in_word;

    typedef struct packed {
        logic [FIDX_W-1:0]       found_index;
        logic signed [SPC_W-1:0] spacing;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_CMP_M,
        ST_LOOP,
        ST_SP_A,
        ST_SP_B,
        ST_SP_C
    } t_step;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_CHK_LO,
        OP_CHK_HI,
        OP_CMP_M,
        OP_LOOP,
        OP_SP_A,
        OP_SP_B,
        OP_SP_C
    } t_op;

    typedef enum logic [2:0] {
        A_ZERO,
        A_HI,
        A_MID,
        A_SIDX,
        A_SIDX1
    } t_asel;

    typedef struct packed {
        t_asel asel;
        t_op   op;
        t_step next_step;
        t_step jump_step;
    } t_uword;

    function automatic t_uword f_ucode(input t_step step);
        t_uword uw;
        unique case (step)
            ST_IDLE:   uw = '{A_ZERO,  OP_WAIT,   ST_CHK_LO, ST_IDLE};
            ST_CHK_LO: uw = '{A_HI,    OP_CHK_LO, ST_CHK_HI, ST_SP_A};
            ST_CHK_HI: uw = '{A_MID,   OP_CHK_HI, ST_CMP_M,  ST_SP_A};
            ST_CMP_M:  uw = '{A_MID,   OP_CMP_M,  ST_LOOP,   ST_SP_A};
            ST_LOOP:   uw = '{A_MID,   OP_LOOP,   ST_SP_A,   ST_CMP_M};
            ST_SP_A:   uw = '{A_SIDX,  OP_SP_A,   ST_SP_B,   ST_SP_B};
            ST_SP_B:   uw = '{A_SIDX1, OP_SP_B,   ST_SP_C,   ST_SP_C};
            ST_SP_C:   uw = '{A_ZERO,  OP_SP_C,   ST_IDLE,   ST_IDLE};
        endcase
        return uw;
    endfunction

endpackage

// ----- src/saxis_seq.sv -----
// Microcode sequencer: step counter and control-store lookup.
// Depends on saxis_pkg.
module saxis_seq
    import saxis_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_jump,
    output t_step  o_step,
    output t_uword o_uword
);

    t_step r_step;
    t_step n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_uword = f_ucode(r_step);
        n_step  = i_jump ? o_uword.jump_step : o_uword.next_step;
    end

    assign o_step = r_step;

endmodule

// ----- src/sorted_axis_index_search_core.sv -----
// Top level of the sorted axis index search: sample table, datapath and sequencer.
// Depends on saxis_pkg and saxis_seq.

// A write word (func 0) is taken while idle and leaves busy low. A query word
// (func 1) keeps busy high until its result is formed: it may clamp to the first
// entry or to the last, or else run k halving steps, k at most about
// log2(sample_count); an exact hit ends the search early. The steps are shaped by the
// single read port of the sample table: one table read per microcode step, two steps
// per halving. The result appears with o_strobe for one cycle right after busy falls,
// and a new word may be started in that same cycle. Results cannot be held off.
module sorted_axis_index_search_core
    import saxis_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_word         i_word,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output logic             o_strobe,
    output t_out_word        o_word
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = AW + 1;
    localparam int XW = ((AW + 1 > CNT_W) ? AW + 1 : CNT_W) + 1;
    localparam int CW = (SAMPLE_BITS > SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam int EW = (SAMPLE_BITS + 1 > SPC_W + 1) ? SAMPLE_BITS + 1 : SPC_W + 1;
    localparam logic signed [EW-1:0] LIM_HI = EW'(32'h7FFF_FFFF);
    localparam logic signed [EW-1:0] LIM_LO = ~LIM_HI;

    t_step  w_step;
    t_uword w_uw;
    logic   w_jump;

    saxis_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jump  (w_jump),
        .o_step  (w_step),
        .o_uword (w_uw)
    );

    logic [SAMPLE_BITS-1:0] r_table [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [AW-1:0]          w_raddr;
    logic                   w_wr;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [SMP_W-1:0]       r_q;
    logic signed [IW-1:0]   r_lo;
    logic signed [IW-1:0]   r_hi;
    logic signed [IW-1:0]   r_m;
    logic [AW-1:0]          r_found;
    logic [AW-1:0]          r_sidx;
    logic [SAMPLE_BITS-1:0] r_a;
    logic                   r_strobe;
    t_out_word              r_out;

    logic                   w_acc_q;
    logic [IW:0]            w_sum;
    logic signed [IW-1:0]   w_mid;
    logic [CW-1:0]          w_qx;
    logic [CW-1:0]          w_dx;
    logic [XW-1:0]          w_fx;
    logic [XW-1:0]          w_lastx;
    logic [XW-1:0]          w_sx;
    logic [AW-1:0]          w_sidx;
    logic signed [EW-1:0]   w_diff;
    logic signed [SPC_W-1:0] w_spc;

    assign busy    = (w_step != ST_IDLE);
    assign w_acc_q = start && !busy && (i_word.func == FN_QUERY);
    assign w_wr    = start && !busy && (i_word.func == FN_WRITE)
                     && (32'(i_word.write_index) < 32'(TABLE_DEPTH));

    assign w_sum = {r_lo[IW-1], r_lo} + {r_hi[IW-1], r_hi};
    assign w_mid = w_sum[IW:1];
    assign w_qx  = CW'(r_q);
    assign w_dx  = CW'(r_rd);

    // spacing index: found limited to count-2
    assign w_fx    = XW'(r_found);
    assign w_lastx = XW'(r_count) - XW'(1);
    assign w_sx    = (w_fx >= w_lastx) ? (XW'(r_count) - XW'(2)) : w_fx;
    assign w_sidx  = w_sx[AW-1:0];

    assign w_diff = $signed(EW'(r_rd)) - $signed(EW'(r_a));

    always_comb begin
        if (r_count < CNT_W'(2)) begin
            w_spc = '0;
        end else if (w_diff > LIM_HI) begin
            w_spc = LIM_HI[SPC_W-1:0];
        end else if (w_diff < LIM_LO) begin
            w_spc = LIM_LO[SPC_W-1:0];
        end else begin
            w_spc = w_diff[SPC_W-1:0];
        end
    end

    always_comb begin
        unique case (w_uw.op)
            OP_WAIT:   w_jump = !w_acc_q;
            OP_CHK_LO: w_jump = (w_qx <= w_dx);
            OP_CHK_HI: w_jump = (w_qx >= w_dx);
            OP_CMP_M:  w_jump = (w_qx == w_dx);
            OP_LOOP:   w_jump = (r_lo < r_hi);
            default:   w_jump = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_uw.asel)
            A_ZERO:  w_raddr = '0;
            A_HI:    w_raddr = r_hi[AW-1:0];
            A_MID:   w_raddr = w_mid[AW-1:0];
            A_SIDX:  w_raddr = w_sidx;
            A_SIDX1: w_raddr = r_sidx + AW'(1);
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_table[AW'(i_word.write_index)] <= SAMPLE_BITS'(i_word.sample_value);
        end
        r_rd <= r_table[w_raddr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                n_count = CNT_W'(1);
            end else if (32'(i_cfg_wdata) > 32'(TABLE_DEPTH)) begin
                n_count = CNT_W'(TABLE_DEPTH);
            end else begin
                n_count = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CNT_W'(1);
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= (w_uw.op == OP_SP_C);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (w_uw.op)
            OP_WAIT: begin
                if (w_acc_q) begin
                    r_q  <= i_word.query_wavelength;
                    r_lo <= '0;
                    r_hi <= IW'(r_count) - IW'(1);
                end
            end
            OP_CHK_LO: begin
                if (w_jump) begin
                    r_found <= '0;
                end
            end
            OP_CHK_HI: begin
                if (w_jump) begin
                    r_found <= r_hi[AW-1:0];
                end else begin
                    r_m <= w_mid;
                end
            end
            OP_CMP_M: begin
                if (w_qx < w_dx) begin
                    r_hi <= r_m - IW'(1);
                end else if (w_qx > w_dx) begin
                    r_lo <= r_m + IW'(1);
                end else begin
                    r_found <= r_m[AW-1:0];
                end
            end
            OP_LOOP: begin
                if (w_jump) begin
                    r_m <= w_mid;
                end else begin
                    r_found <= r_lo[AW-1:0];
                end
            end
            OP_SP_A: r_sidx <= w_sidx;
            OP_SP_B: r_a <= r_rd;
            OP_SP_C: begin
                r_out.found_index <= FIDX_W'(r_found);
                r_out.spacing     <= w_spc;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

`ifndef NO_ASSERTIONS
    a_strobe_after_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_step == ST_SP_C))
        else $error("result strobe without a finished query");

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_q |=> busy)
        else $error("accepted query did not start the sequence");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.func == FN_WRITE) |=> (!busy && !o_strobe))
        else $error("write word started a sequence");

    a_mid_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step == ST_CMP_M) |-> (r_lo <= r_m && r_m < r_hi))
        else $error("probe outside the search window");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0)
        else $error("sample count is zero");
`endif

endmodule
